/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the cycle detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/kcd_pkg.sv */
// Types and fixed constants of the Kahn cycle detector.
`timescale 1ns / 1ps

package kcd_pkg;

   // Width of node count, ordered count and node sweep counter
   localparam int CNT_W = 9;
   // Width of a node index carried by an edge
   localparam int EDGE_W = 8;
   // Largest node count the count register can express
   localparam int NODE_CAP = 511;
   // Largest number of nodes an edge index can reach
   localparam int EDGE_NODES = 256;
   // Node count after reset
   localparam logic [CNT_W-1:0] NODE_COUNT_RST = 9'd256;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_LOAD   = 7'b0000010,
      ST_SEED   = 7'b0000100,
      ST_POP    = 7'b0001000,
      ST_FETCH  = 7'b0010000,
      ST_SCAN   = 7'b0100000,
      ST_REPORT = 7'b1000000
   } state_type;

endpackage

/* rtl/core/kahn_cycle_detector.sv */
// Edge requests are taken one per cycle while loading; a last request starts the check, which
// seeds every node, then reads all stored edges for every node popped.
// The result sits in an output register; the next graph may load while it waits.
// Throughput: one edge per cycle while loading, bound by the single in-degree write port.
// Reset is synchronous, active high; after reset and after each check a clearing pass zeroes
// all min(MAX_NODES, 256) in-degree entries while no request is taken.
`timescale 1ns / 1ps

module kahn_cycle_detector #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_we,
   input  logic [kcd_pkg::CNT_W-1:0]    csr_wdata,
   // edge requests
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_edge_valid,
   input  logic [kcd_pkg::EDGE_W-1:0]   req_edge_from,
   input  logic [kcd_pkg::EDGE_W-1:0]   req_edge_to,
   input  logic                         req_is_last,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_acyclic,
   output logic [kcd_pkg::CNT_W-1:0]    rsp_ordered_nodes,
   output logic                         rsp_edge_dropped
);
   import kcd_pkg::*;

`include "assert_macros.svh"

   localparam int NODE_MEM = (MAX_NODES < EDGE_NODES) ? MAX_NODES : EDGE_NODES;
   localparam int IA_W     = $clog2(NODE_MEM);
   localparam int CNT_CAP  = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
   localparam int QA_W     = $clog2(CNT_CAP);
   localparam int EA_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ES_W     = $clog2(MAX_EDGES + 1);
   localparam int DEG_W    = ES_W;

   // control registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [ES_W-1:0]      edges_ff, edges_in;
   logic                 drop_ff, drop_in;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     seed_ff, seed_in;
   logic [IA_W-1:0]      clr_ff, clr_in;
   logic [ES_W-1:0]      eidx_ff, eidx_in;
   logic [QA_W-1:0]      node_ff, node_in;
   // pipeline stages
   logic                 ld_v_ff, ld_v_in;
   logic [IA_W-1:0]      ld_addr_ff, ld_addr_in;
   logic                 sv_ff, sv_in;
   logic [CNT_W-1:0]     sid_ff, sid_in;
   logic                 ev_ff, ev_in;
   logic                 av_ff, av_in;
   logic [EDGE_W-1:0]    at_ff, at_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acyclic_ff, rsp_acyclic_in;
   logic [CNT_W-1:0]     rsp_ordered_ff, rsp_ordered_in;
   logic                 rsp_dropped_ff, rsp_dropped_in;

   // memories and their read registers
   logic [EDGE_W-1:0]    src_mem [0:MAX_EDGES-1];
   logic [EDGE_W-1:0]    tgt_mem [0:MAX_EDGES-1];
   logic [DEG_W-1:0]     deg_mem [0:NODE_MEM-1];
   logic [QA_W-1:0]      q_mem   [0:CNT_CAP-1];
   logic [EDGE_W-1:0]    src_q_ff, tgt_q_ff;
   logic [DEG_W-1:0]     deg_q_ff;
   logic [IA_W-1:0]      deg_raddr_ff;
   logic [QA_W-1:0]      q_q_ff;
   // last in-degree write, for forwarding
   logic                 wb_v_ff;
   logic [IA_W-1:0]      wb_addr_ff;
   logic [DEG_W-1:0]     wb_data_ff;

   // combinational
   logic [CNT_W-1:0]     cnt;
   logic                 accept;
   logic                 edge_bad;
   logic                 edge_we;
   logic [IA_W-1:0]      deg_raddr;
   logic [DEG_W-1:0]     deg_rd;
   logic                 deg_we;
   logic [IA_W-1:0]      deg_waddr;
   logic [DEG_W-1:0]     deg_wdata;
   logic                 q_we;
   logic [QA_W-1:0]      q_wdata;

   // effective node count
   assign cnt = (node_count_ff > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : node_count_ff;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid & req_ready;
   assign edge_bad  = (edges_ff >= ES_W'(MAX_EDGES)) || (CNT_W'(req_edge_from) >= cnt)
                      || (CNT_W'(req_edge_to) >= cnt);
   assign edge_we   = accept & req_edge_valid & ~edge_bad;

   // in-degree read with forwarding of the write made at the same edge
   assign deg_rd = (wb_v_ff && (wb_addr_ff == deg_raddr_ff)) ? wb_data_ff : deg_q_ff;

   // in-degree read address by phase
   always_comb begin
      case (state_ff)
         ST_LOAD: deg_raddr = req_edge_to[IA_W-1:0];
         ST_SEED: deg_raddr = seed_ff[IA_W-1:0];
         default: deg_raddr = tgt_q_ff[IA_W-1:0];
      endcase
   end

   // sequencer and datapath control
   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      edges_in       = edges_ff;
      drop_in        = drop_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      seed_in        = seed_ff;
      clr_in         = clr_ff;
      eidx_in        = eidx_ff;
      node_in        = node_ff;
      ld_v_in        = 1'b0;
      ld_addr_in     = req_edge_to[IA_W-1:0];
      sv_in          = 1'b0;
      sid_in         = seed_ff;
      ev_in          = 1'b0;
      av_in          = 1'b0;
      at_in          = tgt_q_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_acyclic_in = rsp_acyclic_ff;
      rsp_ordered_in = rsp_ordered_ff;
      rsp_dropped_in = rsp_dropped_ff;
      deg_we         = 1'b0;
      deg_waddr      = clr_ff;
      deg_wdata      = '0;
      q_we           = 1'b0;
      q_wdata        = sid_ff[QA_W-1:0];

      if (csr_we) begin
         node_count_in = csr_wdata;
      end

      // load stage: finish the in-degree increment
      if (ld_v_ff) begin
         deg_we    = 1'b1;
         deg_waddr = ld_addr_ff;
         deg_wdata = deg_rd + DEG_W'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_ff;
            deg_wdata = '0;
            clr_in    = clr_ff + IA_W'(1);
            if (clr_ff == IA_W'(NODE_MEM - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (accept) begin
               if (req_edge_valid) begin
                  if (edge_bad) begin
                     drop_in = 1'b1;
                  end else begin
                     edges_in = edges_ff + ES_W'(1);
                     ld_v_in  = 1'b1;
                  end
               end
               if (req_is_last) begin
                  state_in = ST_SEED;
                  seed_in  = '0;
               end
            end
         end
         ST_SEED: begin
            // issue one node read a cycle, check the previous one
            if (seed_ff < cnt) begin
               sv_in   = 1'b1;
               seed_in = seed_ff + CNT_W'(1);
            end else if (!sv_ff) begin
               state_in = ST_POP;
            end
            if (sv_ff && ((sid_ff >= CNT_W'(NODE_MEM)) || (deg_rd == '0))) begin
               q_we    = 1'b1;
               q_wdata = sid_ff[QA_W-1:0];
               tail_in = tail_ff + CNT_W'(1);
            end
         end
         ST_POP: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + CNT_W'(1);
               state_in = ST_FETCH;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_FETCH: begin
            node_in  = q_q_ff;
            eidx_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // edge read stage
            if (eidx_ff < edges_ff) begin
               ev_in   = 1'b1;
               eidx_in = eidx_ff + ES_W'(1);
            end else if (!ev_ff && !av_ff) begin
               state_in = ST_POP;
            end
            // source match stage
            av_in = ev_ff && (CNT_W'(src_q_ff) == CNT_W'(node_ff));
            // in-degree decrement stage
            if (av_ff && (deg_rd != '0)) begin
               deg_we    = 1'b1;
               deg_waddr = at_ff[IA_W-1:0];
               deg_wdata = deg_rd - DEG_W'(1);
               if ((deg_rd == DEG_W'(1)) && (CNT_W'(at_ff) < cnt)) begin
                  q_we    = 1'b1;
                  q_wdata = QA_W'(at_ff);
                  tail_in = tail_ff + CNT_W'(1);
               end
            end
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_acyclic_in = (head_ff == cnt);
               rsp_ordered_in = head_ff;
               rsp_dropped_in = drop_ff;
               edges_in       = '0;
               drop_in        = 1'b0;
               head_in        = '0;
               tail_in        = '0;
               clr_in         = '0;
               state_in       = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= NODE_COUNT_RST;
         edges_ff      <= '0;
         drop_ff       <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         seed_ff       <= '0;
         clr_ff        <= '0;
         eidx_ff       <= '0;
         ld_v_ff       <= 1'b0;
         sv_ff         <= 1'b0;
         ev_ff         <= 1'b0;
         av_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wb_v_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         edges_ff      <= edges_in;
         drop_ff       <= drop_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         seed_ff       <= seed_in;
         clr_ff        <= clr_in;
         eidx_ff       <= eidx_in;
         ld_v_ff       <= ld_v_in;
         sv_ff         <= sv_in;
         ev_ff         <= ev_in;
         av_ff         <= av_in;
         rsp_valid_ff  <= rsp_valid_in;
         wb_v_ff       <= deg_we;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff        <= node_in;
      ld_addr_ff     <= ld_addr_in;
      sid_ff         <= sid_in;
      at_ff          <= at_in;
      rsp_acyclic_ff <= rsp_acyclic_in;
      rsp_ordered_ff <= rsp_ordered_in;
      rsp_dropped_ff <= rsp_dropped_in;
      wb_addr_ff     <= deg_waddr;
      wb_data_ff     <= deg_wdata;
   end

   // edge store
   always_ff @(posedge clock) begin
      if (edge_we) begin
         src_mem[edges_ff[EA_W-1:0]] <= req_edge_from;
         tgt_mem[edges_ff[EA_W-1:0]] <= req_edge_to;
      end
      src_q_ff <= src_mem[eidx_ff[EA_W-1:0]];
      tgt_q_ff <= tgt_mem[eidx_ff[EA_W-1:0]];
   end

   // in-degree memory
   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_waddr] <= deg_wdata;
      end
      deg_q_ff     <= deg_mem[deg_raddr];
      deg_raddr_ff <= deg_raddr;
   end

   // ready queue
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff[QA_W-1:0]] <= q_wdata;
      end
      q_q_ff <= q_mem[head_ff[QA_W-1:0]];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_acyclic       = rsp_acyclic_ff;
   assign rsp_ordered_nodes = rsp_ordered_ff;
   assign rsp_edge_dropped  = rsp_dropped_ff;

   // checks
   `ASSERT_HOLDS(a_head_le_tail, clock, reset, head_ff <= tail_ff, "queue head passed tail")
   `ASSERT_HOLDS(a_one_deg_writer, clock, reset, $onehot0({ld_v_ff, (state_ff == ST_CLEAR), av_ff}), "two in-degree writers at once")
   `ASSERT_IMPLIES(a_scan_stage, clock, reset, av_ff, state_ff == ST_SCAN, "decrement stage live outside scan")
   `ASSERT_HOLDS(a_edges_cap, clock, reset, edges_ff <= ES_W'(MAX_EDGES), "edge count above capacity")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the Kahn cycle detector: graph loading, sort verdicts, drops.
`timescale 1ns / 1ps

localparam int NODE_SLOTS = 256;
localparam int EDGE_SLOTS = 1024;

typedef struct packed {
   logic                    acyclic;
   logic [kcd_pkg::CNT_W-1:0] ordered;
   logic                    dropped;
} verdict_type;

// Mirrors the graph held by the block and queues the verdict each last request yields
class graph_checker;
   int unsigned node_reg;
   bit [7:0]    src_mem [EDGE_SLOTS];
   bit [7:0]    dst_mem [EDGE_SLOTS];
   int unsigned indeg [NODE_SLOTS];
   int unsigned edges_held;
   bit          dropped;
   verdict_type pending [$];
   int unsigned failures;

   function new();
      node_reg = kcd_pkg::NODE_COUNT_RST;
      failures = 0;
      clear_graph();
   endfunction

   function void clear_graph();
      foreach (indeg[i]) indeg[i] = 0;
      edges_held = 0;
      dropped = 1'b0;
   endfunction

   function void write_node_count(int unsigned value);
      node_reg = value & 32'h1FF;
   endfunction

   // counts above the node table behave as a full table
   function int unsigned live_nodes();
      return (node_reg > NODE_SLOTS) ? NODE_SLOTS : node_reg;
   endfunction

   // Kahn pass: seed zero in-degree nodes in order, then release targets edge by edge
   function verdict_type topo_sort(int unsigned cnt);
      int unsigned ready_q [$];
      int unsigned node;
      int unsigned t;
      int unsigned done;
      verdict_type v;
      done = 0;
      for (int unsigned n = 0; n < cnt; n++)
         if (indeg[n] == 0) ready_q.insert(ready_q.size(), n);
      while (ready_q.size() != 0) begin
         node = ready_q.pop_front();
         done++;
         for (int unsigned e = 0; e < edges_held; e++) begin
            t = dst_mem[e];
            if (src_mem[e] == node && indeg[t] != 0) begin
               indeg[t]--;
               // targets at or above the current count are lowered but never queued
               if (indeg[t] == 0 && t < cnt) ready_q.insert(ready_q.size(), t);
            end
         end
      end
      v.acyclic = (done == cnt);
      v.ordered = done[kcd_pkg::CNT_W-1:0];
      v.dropped = dropped;
      return v;
   endfunction

   function void note_request(logic ev, logic [7:0] from, logic [7:0] to, logic last);
      int unsigned cnt;
      cnt = live_nodes();
      if (ev) begin
         if (edges_held >= EDGE_SLOTS || from >= cnt || to >= cnt) begin
            dropped = 1'b1;
         end else begin
            src_mem[edges_held] = from;
            dst_mem[edges_held] = to;
            edges_held++;
            indeg[to]++;
         end
      end
      if (last) begin
         pending.insert(pending.size(), topo_sort(cnt));
         clear_graph();
      end
   endfunction

   function void check_verdict(logic acyclic, logic [kcd_pkg::CNT_W-1:0] ordered,
                               logic dropped_flag);
      verdict_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result: acyclic %b ordered %0d dropped %b",
                  $time, acyclic, ordered, dropped_flag);
         failures++;
         return;
      end
      want = pending.pop_front();
      if (acyclic !== want.acyclic) begin
         $display("%0t: acyclic expected %b actual %b", $time, want.acyclic, acyclic);
         failures++;
      end
      if (ordered !== want.ordered) begin
         $display("%0t: ordered_nodes expected %0d actual %0d", $time, want.ordered, ordered);
         failures++;
      end
      if (dropped_flag !== want.dropped) begin
         $display("%0t: edge_dropped expected %b actual %b", $time, want.dropped,
                  dropped_flag);
         failures++;
      end
   endfunction
endclass

module testbench;
   import kcd_pkg::*;

   localparam int IDLE_PCT       = 29;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int ITEM_GOAL      = 1550;
   localparam int GRAPH_GOAL     = 40;

   typedef enum logic [1:0] {SHAPE_DAG, SHAPE_ANY, SHAPE_NOISE} graph_shape_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_we         = 1'b0;
   logic [CNT_W-1:0]   csr_wdata      = '0;
   logic               req_valid      = 1'b0;
   logic               req_edge_valid = 1'b0;
   logic [EDGE_W-1:0]  req_edge_from  = '0;
   logic [EDGE_W-1:0]  req_edge_to    = '0;
   logic               req_is_last    = 1'b0;
   logic               rsp_ready      = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_acyclic;
   logic [CNT_W-1:0]   rsp_ordered_nodes;
   logic               rsp_edge_dropped;

   graph_checker board;
   bit           steady = 1'b0;
   bit           valid_up = 1'b0;
   int unsigned  items_sent = 0;
   int unsigned  quiet_cycles = 0;

   kahn_cycle_detector #(
      .MAX_NODES(NODE_SLOTS),
      .MAX_EDGES(EDGE_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_edge_valid(req_edge_valid),
      .req_edge_from(req_edge_from),
      .req_edge_to(req_edge_to),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_acyclic(rsp_acyclic),
      .rsp_ordered_nodes(rsp_ordered_nodes),
      .rsp_edge_dropped(rsp_edge_dropped)
   );

   initial forever #6 clock = ~clock;

   // Result side: random back-pressure, each accepted verdict checked
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_verdict(rsp_acyclic, rsp_ordered_nodes, rsp_edge_dropped);
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("** kahn_cycle_detector: FAILED **");
      $finish;
   end

   task automatic lower_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // One request, with random idle cycles ahead of it unless in a steady stretch
   task automatic send_request(input logic ev, input logic [7:0] from, input logic [7:0] to,
                               input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         lower_valid();
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      valid_up        = 1'b1;
      req_edge_valid <= ev;
      req_edge_from  <= from;
      req_edge_to    <= to;
      req_is_last    <= last;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.note_request(ev, from, to, last);
      items_sent++;
   endtask

   task automatic drain_results();
      lower_valid();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Register write only once the block has gone quiet, clearing pass included
   task automatic write_node_count(input int unsigned value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[CNT_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      board.write_node_count(value);
   endtask

   initial begin
      int unsigned     graphs;
      int unsigned     eff;
      int unsigned     n_edges;
      int unsigned     pick;
      graph_shape_type shape;
      logic            ev;
      logic [7:0]      a;
      logic [7:0]      b;
      logic [7:0]      tmp;

      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset count of 256, full-range node indices
      send_request(1'b1, 8'd0, 8'd255, 1'b0);
      send_request(1'b1, 8'd255, 8'd128, 1'b1);
      // two-node cycle closed by a finish-only request with ignored endpoints
      send_request(1'b1, 8'd1, 8'd2, 1'b0);
      send_request(1'b1, 8'd2, 8'd1, 1'b0);
      send_request(1'b0, 8'd255, 8'd255, 1'b1);
      // zero nodes: every edge dropped, empty graph counts as acyclic
      write_node_count(0);
      send_request(1'b1, 8'd0, 8'd0, 1'b0);
      send_request(1'b0, 8'hAA, 8'h55, 1'b1);
      // count above the table limits to the table size; self loop
      write_node_count(511);
      send_request(1'b1, 8'd5, 8'd5, 1'b1);
      // single node, out-of-range edge dropped, last request carries a self loop
      write_node_count(1);
      send_request(1'b1, 8'd0, 8'd1, 1'b0);
      send_request(1'b1, 8'd0, 8'd0, 1'b1);
      // count lowered mid-graph: a stored target above it is released, not queued
      write_node_count(8);
      send_request(1'b1, 8'd1, 8'd6, 1'b0);
      send_request(1'b1, 8'd6, 8'd7, 1'b0);
      write_node_count(4);
      send_request(1'b1, 8'd2, 8'd3, 1'b0);
      send_request(1'b1, 8'hFF, 8'h00, 1'b0);
      send_request(1'b0, 8'h00, 8'h00, 1'b1);
      write_node_count(256);
      send_request(1'b1, 8'h7F, 8'h80, 1'b1);

      // Edge store filled past capacity on two nodes, back to back
      write_node_count(2);
      steady = 1'b1;
      for (int i = 0; i < EDGE_SLOTS + 6; i++)
         send_request(1'b1, 8'($urandom_range(1)), 8'($urandom_range(1)),
                      i == EDGE_SLOTS + 5);
      steady = 1'b0;

      // Random graphs
      graphs = 0;
      while (items_sent < ITEM_GOAL || graphs < GRAPH_GOAL) begin
         steady = (graphs >= 12 && graphs < 20);
         if (graphs == 0 || $urandom_range(99) < 35) begin
            pick = $urandom_range(99);
            if (pick < 60)      write_node_count($urandom_range(1, 12));
            else if (pick < 70) write_node_count(0);
            else if (pick < 85) write_node_count($urandom_range(13, 255));
            else                write_node_count($urandom_range(256, 511));
         end
         eff = board.live_nodes();
         n_edges = (eff > 16) ? $urandom_range(0, 6) : $urandom_range(0, 24);
         pick = $urandom_range(99);
         shape = (pick < 45) ? SHAPE_DAG : (pick < 85) ? SHAPE_ANY : SHAPE_NOISE;
         for (int unsigned i = 0; i <= n_edges; i++) begin
            ev = 1'b1;
            if (eff == 0 || shape == SHAPE_NOISE) begin
               a = 8'($urandom_range(255));
               b = 8'($urandom_range(255));
               ev = 1'($urandom_range(1));
            end else begin
               a = 8'($urandom_range(eff - 1));
               b = 8'($urandom_range(eff - 1));
            end
            if (shape == SHAPE_DAG) begin
               if (a > b) begin
                  tmp = a;
                  a = b;
                  b = tmp;
               end
               // self loops would spoil the acyclic shape; send filler instead
               if (a == b) begin
                  ev = 1'b0;
                  a = 8'($urandom_range(255));
               end
            end
            if (i == n_edges && $urandom_range(1) == 0) ev = 1'b0;
            send_request(ev, a, b, i == n_edges);
         end
         graphs++;
         // hold the sender now and then until every verdict is back
         if ($urandom_range(9) == 0) drain_results();
      end
      steady = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending.size() == 0)
         $display("** kahn_cycle_detector: PASSED **");
      else
         $display("** kahn_cycle_detector: FAILED **");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/kcd_pkg.sv
rtl/core/kahn_cycle_detector.sv
test/testbench.sv
